@@ sv/lrup_pkg.sv @@
// Package for the LRU replacement block: transaction types, codes and defaults.
package lrup_pkg;

    localparam int SET_W      = 11;
    localparam int WAY_W      = 4;
    localparam int PIN_W      = 16;
    localparam int WAYS_DEF   = 16;
    localparam int SETS_DEF   = 2048;

    localparam logic KIND_VICTIM = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way_index;
        logic [PIN_W-1:0]  pinned_ways;
        logic              was_hit;
        logic              access_is_writeback;
    } lrup_req_t;

    typedef struct packed {
        logic [WAY_W-1:0]  victim_way;
        logic              no_victim;
    } lrup_rsp_t;

endpackage

@@ sv/lru_replacement_with_pinning_top.sv @@
// True-LRU replacement with pinned ways: rank memory, update and victim selection.
//
// Request channel (req_valid/req_ready/req): one transaction is either a recency
// update (kind = update) or a victim request (kind = victim). Updates give no
// response; a writeback hit, an out-of-range set or an out-of-range way is dropped.
// Response channel (rsp_valid/rsp_ready/rsp): one transaction per victim request,
// in request order, carrying victim_way and no_victim (all ways pinned or set out
// of range; victim_way is then 0).
// Ranks live in a single-port SETS x (WAYS*log2(WAYS)) memory with registered read.
// The row is read at the accepting edge and modified and written back in the next
// cycle (ST_EXEC), so a new request is taken only after ST_EXEC is left; the
// response is registered from ST_EXEC. This read-modify-write on the one memory
// port sets the throughput.
// After reset the block sweeps the memory, one set per cycle (all SETS sets, 2048 by
// default), loading rank = way index; req_ready stays low during the sweep.
// A stalled response is held in the output register; a new request is still
// accepted, and a following victim request waits until the register frees up.
module lru_replacement_with_pinning_top
    import lrup_pkg::*;
#(
    parameter int WAYS = WAYS_DEF,
    parameter int SETS = SETS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  lrup_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output lrup_rsp_t rsp
);

    localparam int RW    = $clog2(WAYS);
    localparam int ROW_W = WAYS * RW;
    localparam int AW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int LV    = RW;
    localparam int P     = 1 << LV;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t           state_reg, state_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    lrup_req_t        item_reg, item_next;
    logic             rsp_valid_reg, rsp_valid_next;
    lrup_rsp_t        rsp_reg, rsp_next;
    logic [ROW_W-1:0] rd_row_reg;

    logic [ROW_W-1:0] rank_mem [SETS];

    logic                  req_fire;
    logic [AW+SET_W-1:0]   req_set_ext;
    logic [AW+SET_W-1:0]   item_set_ext;
    logic [RW+WAY_W-1:0]   item_way_ext;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         item_addr;
    logic [RW-1:0]         way_sel;
    logic                  set_ok;
    logic                  way_ok;
    logic                  upd_ok;
    logic [RW-1:0]         old_rank;
    logic [ROW_W-1:0]      upd_row;
    logic [ROW_W-1:0]      init_row;
    logic                  mem_we;
    logic [AW-1:0]         wr_addr;
    logic [ROW_W-1:0]      wr_row;
    logic [31:0]           pin_ext;
    logic [WAYS-1:0]       pin_vec;
    logic [RW:0]           key_lv [LV+1][P];
    logic [RW-1:0]         idx_lv [LV+1][P];
    logic                  vic_found;
    logic [RW-1:0]         vic_idx;
    logic [RW+WAY_W-1:0]   vic_ext;
    logic                  rsp_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign req_set_ext  = {{AW{1'b0}}, req.set_index};
    assign rd_addr      = req_set_ext[AW-1:0];
    assign item_set_ext = {{AW{1'b0}}, item_reg.set_index};
    assign item_addr    = item_set_ext[AW-1:0];
    assign item_way_ext = {{RW{1'b0}}, item_reg.way_index};
    assign way_sel      = item_way_ext[RW-1:0];

    assign set_ok = 32'(item_reg.set_index) < 32'(SETS);
    assign way_ok = 32'(item_reg.way_index) < 32'(WAYS);
    assign upd_ok = (item_reg.kind == KIND_UPDATE) && set_ok && way_ok
                    && !(item_reg.was_hit && item_reg.access_is_writeback);

    // promote: selected way to rank 0, ages everything at or below its old rank
    assign old_rank = rd_row_reg[way_sel*RW +: RW];

    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            init_row[i*RW +: RW] = RW'(i);
            if (RW'(i) == way_sel)
                upd_row[i*RW +: RW] = '0;
            else if (rd_row_reg[i*RW +: RW] <= old_rank)
                upd_row[i*RW +: RW] = rd_row_reg[i*RW +: RW] + RW'(1);
            else
                upd_row[i*RW +: RW] = rd_row_reg[i*RW +: RW];
        end
    end

    assign mem_we  = (state_reg == ST_CLEAR) || ((state_reg == ST_EXEC) && upd_ok);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : item_addr;
    assign wr_row  = (state_reg == ST_CLEAR) ? init_row : upd_row;

    // victim search: max-rank tree, left (lower index) wins ties
    assign pin_ext = {{(32-PIN_W){1'b0}}, item_reg.pinned_ways};

    always_comb
    begin
        for (int l = 0; l <= LV; l++)
        begin
            for (int j = 0; j < P; j++)
            begin
                key_lv[l][j] = '0;
                idx_lv[l][j] = '0;
            end
        end
        for (int i = 0; i < WAYS; i++)
        begin
            pin_vec[i]   = pin_ext[i];
            key_lv[0][i] = {!pin_ext[i], rd_row_reg[i*RW +: RW]};
            idx_lv[0][i] = RW'(i);
        end
        for (int l = 0; l < LV; l++)
        begin
            for (int j = 0; j < (P >> (l + 1)); j++)
            begin
                if (key_lv[l][2*j+1] > key_lv[l][2*j])
                begin
                    key_lv[l+1][j] = key_lv[l][2*j+1];
                    idx_lv[l+1][j] = idx_lv[l][2*j+1];
                end
                else
                begin
                    key_lv[l+1][j] = key_lv[l][2*j];
                    idx_lv[l+1][j] = idx_lv[l][2*j];
                end
            end
        end
    end

    assign vic_found = key_lv[LV][0][RW] && set_ok;
    assign vic_idx   = idx_lv[LV][0];
    assign vic_ext   = {{WAY_W{1'b0}}, vic_idx};
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        item_next      = item_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (32'(clr_cnt_reg) == 32'(SETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    item_next  = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (item_reg.kind == KIND_UPDATE)
                    state_next = ST_IDLE;
                else if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.no_victim   = !vic_found;
                    rsp_next.victim_way  = vic_found ? vic_ext[WAY_W-1:0] : '0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            rank_mem[wr_addr] <= wr_row;
        if (req_fire)
            rd_row_reg <= rank_mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_rsp_from_victim: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> item_reg.kind == KIND_VICTIM)
        else $error("response raised for an update transaction");

    a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.no_victim |-> rsp_reg.victim_way == '0)
        else $error("no_victim response with nonzero way");

    a_victim_unpinned: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC && item_reg.kind == KIND_VICTIM && vic_found
        |-> !pin_vec[vic_idx])
        else $error("pinned way chosen as victim");

    a_write_only_update: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we && state_reg == ST_EXEC |-> item_reg.kind == KIND_UPDATE)
        else $error("rank write from a victim request");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_ready |=> rsp_valid_reg && $stable(rsp_reg))
        else $error("stalled response changed");
`endif

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for lru_replacement_with_pinning_top: random and directed traffic.
module testbench
    import lrup_pkg::*;
;

    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 300;

    class victim_checker;
        logic [WAY_W-1:0] rank [SETS_DEF][WAYS_DEF];
        lrup_rsp_t        victim_due[$];
        int               errors;

        function new();
            errors = 0;
            for (int s = 0; s < SETS_DEF; s++)
                for (int w = 0; w < WAYS_DEF; w++)
                    rank[s][w] = WAY_W'(w);
        endfunction

        function void note_request(lrup_req_t r);
            lrup_rsp_t        res;
            logic             found;
            logic [WAY_W-1:0] best_rank;
            logic [WAY_W-1:0] old;
            if (r.kind == KIND_VICTIM)
            begin
                res       = '0;
                found     = 1'b0;
                best_rank = '0;
                for (int i = 0; i < WAYS_DEF; i++)
                begin
                    if (!r.pinned_ways[i] && (!found || rank[r.set_index][i] > best_rank))
                    begin
                        found          = 1'b1;
                        best_rank      = rank[r.set_index][i];
                        res.victim_way = WAY_W'(i);
                    end
                end
                res.no_victim = !found;
                victim_due.push_back(res);
            end
            else if (!(r.was_hit && r.access_is_writeback))
            begin
                old = rank[r.set_index][r.way_index];
                for (int i = 0; i < WAYS_DEF; i++)
                    if (rank[r.set_index][i] <= old)
                        rank[r.set_index][i] = rank[r.set_index][i] + 1'b1;
                rank[r.set_index][r.way_index] = '0;
            end
        endfunction

        function void check_response(lrup_rsp_t got);
            lrup_rsp_t want;
            if (victim_due.size() == 0)
            begin
                $error("unexpected response: victim_way %0d no_victim %0b",
                       got.victim_way, got.no_victim);
                errors++;
                return;
            end
            want = victim_due.pop_front();
            if (got.victim_way !== want.victim_way)
            begin
                $error("victim_way: expected %0d, actual %0d", want.victim_way, got.victim_way);
                errors++;
            end
            if (got.no_victim !== want.no_victim)
            begin
                $error("no_victim: expected %0b, actual %0b", want.no_victim, got.no_victim);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_ready;
    lrup_req_t req;
    logic      rsp_valid;
    logic      rsp_ready;
    lrup_rsp_t rsp;

    victim_checker vc = new();
    int            recv_stall_pct = 0;
    bit            hold_off = 1'b0;
    int            idle_cycles = 0;

    lru_replacement_with_pinning_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic lrup_req_t mk(logic k, int s, int w, int pins, logic hit, logic wb);
        lrup_req_t r;
        r.kind                = k;
        r.set_index           = SET_W'(s);
        r.way_index           = WAY_W'(w);
        r.pinned_ways         = PIN_W'(pins);
        r.was_hit             = hit;
        r.access_is_writeback = wb;
        return r;
    endfunction

    function automatic lrup_req_t random_item();
        lrup_req_t r;
        int        pick;
        r.kind = ($urandom_range(0, 99) < 45) ? KIND_VICTIM : KIND_UPDATE;
        // mostly a few hot sets so the ranks get well shuffled
        if ($urandom_range(0, 9) < 7)
        begin
            pick        = $urandom_range(0, 3);
            r.set_index = (pick == 3) ? SET_W'(SETS_DEF - 1) : SET_W'(pick);
        end
        else
            r.set_index = SET_W'($urandom);
        r.way_index = WAY_W'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: r.pinned_ways = PIN_W'($urandom);
            4, 5:       r.pinned_ways = '0;
            6:          r.pinned_ways = '1;
            7, 8:       r.pinned_ways = ~(PIN_W'(1) << $urandom_range(0, PIN_W - 1));
            default:    r.pinned_ways = PIN_W'($urandom & $urandom);
        endcase
        r.was_hit             = 1'($urandom);
        r.access_is_writeback = ($urandom_range(0, 3) == 0);
        return r;
    endfunction

    task automatic send(lrup_req_t r);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        vc.note_request(r);
    endtask

    task automatic run_phase(int n, int idle_pct, int stall_pct);
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < idle_pct)
            begin
                req_valid <= 1'b0;
                do
                    @(posedge clk);
                while ($urandom_range(0, 99) < idle_pct);
            end
            send(random_item());
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (vc.victim_due.size() != 0)
            @(posedge clk);
    endtask

    // response side
    initial
    begin
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                vc.check_response(rsp);
            if (hold_off)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("lru_replacement_with_pinning_top: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk(KIND_VICTIM, 0, 0, 16'h0000, 1'b0, 1'b0));
        send(mk(KIND_VICTIM, 0, 0, 16'hFFFF, 1'b0, 1'b0));
        send(mk(KIND_VICTIM, 0, 0, 16'h8000, 1'b0, 1'b0));
        send(mk(KIND_UPDATE, 0, 15, 16'h0000, 1'b1, 1'b0));
        send(mk(KIND_VICTIM, 0, 0, 16'h0000, 1'b0, 1'b0));
        // writeback hit: ranks untouched
        send(mk(KIND_UPDATE, 0, 14, 16'hFFFF, 1'b1, 1'b1));
        send(mk(KIND_VICTIM, 0, 0, 16'h0000, 1'b0, 1'b0));
        // writeback fill: applied
        send(mk(KIND_UPDATE, 0, 14, 16'h0000, 1'b0, 1'b1));
        send(mk(KIND_VICTIM, 0, 0, 16'h0000, 1'b0, 1'b0));
        send(mk(KIND_UPDATE, SETS_DEF - 1, 0, 16'h0000, 1'b0, 1'b0));
        send(mk(KIND_VICTIM, SETS_DEF - 1, 0, 16'h0000, 1'b0, 1'b0));
        send(mk(KIND_VICTIM, SETS_DEF - 1, 15, 16'hFFFE, 1'b1, 1'b1));
        send(mk(KIND_UPDATE, SETS_DEF - 1, 0, 16'h0000, 1'b1, 1'b0));
        send(mk(KIND_VICTIM, SETS_DEF - 1, 0, 16'h7FFF, 1'b0, 1'b0));
        send(mk(KIND_VICTIM, 11'h555, 5, 16'hAAAA, 1'b0, 1'b0));
        send(mk(KIND_VICTIM, 11'h2AA, 10, 16'h5555, 1'b0, 1'b0));
        send(mk(KIND_UPDATE, 11'h555, 10, 16'h5555, 1'b1, 1'b0));
        send(mk(KIND_VICTIM, 11'h555, 0, 16'h0000, 1'b0, 1'b0));
        send(mk(KIND_UPDATE, 11'h2AA, 5, 16'hAAAA, 1'b0, 1'b0));
        send(mk(KIND_VICTIM, 11'h2AA, 15, 16'hFFFF, 1'b1, 1'b0));

        run_phase(150, 0, 0);
        hold_off = 1'b1;
        run_phase(60, 0, 0);
        drain();
        run_phase(250, 84, 0);
        run_phase(250, 0, 84);
        run_phase(250, 24, 24);
        run_phase(40, 0, 0);

        recv_stall_pct = 0;
        drain();
        repeat (8) @(posedge clk);
        if (vc.errors == 0 && vc.victim_due.size() == 0)
            $display("lru_replacement_with_pinning_top: match");
        else
            $display("lru_replacement_with_pinning_top: mismatch");
        $finish;
    end
endmodule

@@ lru_replacement_with_pinning_top.f @@
sv/lrup_pkg.sv
sv/lru_replacement_with_pinning_top.sv
bench/testbench.sv
